/* src/mbm_pkg.sv */
`timescale 1ns / 1ps
package mbm_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int COORD_BITS_DEF = 10;
    localparam int LIMIT_BITS     = 10;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_X      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_X      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_Y      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_Y      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_W     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_H     = 3'd6;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd32;
    localparam int GRID_W_RESET = 38;
    localparam int GRID_H_RESET = 25;

    typedef struct packed {
        logic valid;
        logic tag;
        logic neg;
    } div_ctrl_t;

endpackage

/* src/mbm_div_cell.sv */
`timescale 1ns / 1ps
module mbm_div_cell #(
    parameter int COORD_BITS = mbm_pkg::COORD_BITS_DEF,
    parameter int QUO_BITS   = mbm_pkg::WORD_BITS_DEF + mbm_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mbm_pkg::div_ctrl_t    ctrl_in,
    input  logic [COORD_BITS-1:0] divisor_in,
    input  logic [COORD_BITS-1:0] rem_in,
    input  logic [QUO_BITS-1:0]   dq_in,
    output mbm_pkg::div_ctrl_t    ctrl_out,
    output logic [COORD_BITS-1:0] divisor_out,
    output logic [COORD_BITS-1:0] rem_out,
    output logic [QUO_BITS-1:0]   dq_out
);
    import mbm_pkg::*;

    div_ctrl_t             ctrl_reg;
    logic [COORD_BITS-1:0] divisor_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [COORD_BITS-1:0] rem_next;
    logic [QUO_BITS-1:0]   dq_reg;
    logic [QUO_BITS-1:0]   dq_next;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  fits;

    always_comb
    begin
        trial    = {rem_in, dq_in[QUO_BITS-1]};
        diff     = trial - {1'b0, divisor_in};
        fits     = (trial >= {1'b0, divisor_in});
        rem_next = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        dq_next  = {dq_in[QUO_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_in;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
    end

    assign ctrl_out    = ctrl_reg;
    assign divisor_out = divisor_reg;
    assign rem_out     = rem_reg;
    assign dq_out      = dq_reg;

endmodule

/* src/mbm_map_chain.sv */
`timescale 1ns / 1ps
module mbm_map_chain #(
    parameter int WORD_BITS  = mbm_pkg::WORD_BITS_DEF,
    parameter int COORD_BITS = mbm_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [COORD_BITS-1:0]       pos_x,
    input  logic [COORD_BITS-1:0]       pos_y,
    input  logic signed [WORD_BITS-1:0] min_x,
    input  logic signed [WORD_BITS-1:0] max_x,
    input  logic signed [WORD_BITS-1:0] min_y,
    input  logic signed [WORD_BITS-1:0] max_y,
    input  logic [COORD_BITS-1:0]       grid_w,
    input  logic [COORD_BITS-1:0]       grid_h,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] c_re,
    output logic signed [WORD_BITS-1:0] c_im
);
    import mbm_pkg::*;

    localparam int QUO_BITS = WORD_BITS + COORD_BITS;
    localparam int SUM_BITS = QUO_BITS + 2;

    logic                  second_reg;
    logic                  sel_tag;
    logic [WORD_BITS-1:0]  sel_lo;
    logic [WORD_BITS-1:0]  sel_hi;
    logic [COORD_BITS-1:0] sel_pos;
    logic [COORD_BITS-1:0] sel_grid;
    logic [WORD_BITS:0]    span;
    logic [WORD_BITS:0]    span_abs;

    div_ctrl_t             feed_ctrl_reg;
    logic [WORD_BITS-1:0]  feed_mag_reg;
    logic [COORD_BITS-1:0] feed_pos_reg;
    logic [COORD_BITS-1:0] feed_grid_reg;

    div_ctrl_t             prod_ctrl_reg;
    logic [QUO_BITS-1:0]   prod_reg;
    logic [QUO_BITS-1:0]   prod_next;
    logic [COORD_BITS-1:0] prod_grid_reg;

    div_ctrl_t             ctrl_w    [0:QUO_BITS];
    logic [COORD_BITS-1:0] divisor_w [0:QUO_BITS];
    logic [COORD_BITS-1:0] rem_w     [0:QUO_BITS];
    logic [QUO_BITS-1:0]   dq_w      [0:QUO_BITS];

    div_ctrl_t             last;
    logic [WORD_BITS-1:0]  out_lo;
    logic [QUO_BITS:0]     q_signed;
    logic [SUM_BITS-1:0]   sum;
    logic [SUM_BITS-WORD_BITS:0] upper_bits;
    logic [WORD_BITS-1:0]  c_next;

    logic                  done_reg;
    logic signed [WORD_BITS-1:0] c_re_reg;
    logic signed [WORD_BITS-1:0] c_im_reg;

    always_comb
    begin
        sel_tag  = second_reg;
        sel_lo   = sel_tag ? min_y : min_x;
        sel_hi   = sel_tag ? max_y : max_x;
        sel_pos  = sel_tag ? pos_y : pos_x;
        sel_grid = sel_tag ? grid_h : grid_w;
        span     = {sel_hi[WORD_BITS-1], sel_hi} - {sel_lo[WORD_BITS-1], sel_lo};
        span_abs = span[WORD_BITS] ? ((WORD_BITS+1)'(0) - span) : span;
        prod_next = feed_mag_reg * feed_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            feed_ctrl_reg <= '0;
            prod_ctrl_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            second_reg          <= start;
            feed_ctrl_reg.valid <= start || second_reg;
            feed_ctrl_reg.tag   <= sel_tag;
            feed_ctrl_reg.neg   <= span[WORD_BITS];
            prod_ctrl_reg       <= feed_ctrl_reg;
            done_reg            <= last.valid && last.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        feed_mag_reg  <= span_abs[WORD_BITS-1:0];
        feed_pos_reg  <= sel_pos;
        feed_grid_reg <= sel_grid;
        prod_reg      <= prod_next;
        prod_grid_reg <= feed_grid_reg;
    end

    assign ctrl_w[0]    = prod_ctrl_reg;
    assign divisor_w[0] = prod_grid_reg;
    assign rem_w[0]     = '0;
    assign dq_w[0]      = prod_reg;

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        mbm_div_cell #(
            .COORD_BITS (COORD_BITS),
            .QUO_BITS   (QUO_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl_in     (ctrl_w[i]),
            .divisor_in  (divisor_w[i]),
            .rem_in      (rem_w[i]),
            .dq_in       (dq_w[i]),
            .ctrl_out    (ctrl_w[i+1]),
            .divisor_out (divisor_w[i+1]),
            .rem_out     (rem_w[i+1]),
            .dq_out      (dq_w[i+1])
        );
    end

    // apply sign, add window minimum, clamp; zero grid yields the minimum
    always_comb
    begin
        last       = ctrl_w[QUO_BITS];
        out_lo     = last.tag ? min_y : min_x;
        q_signed   = last.neg ? ((QUO_BITS+1)'(0) - {1'b0, dq_w[QUO_BITS]})
                              : {1'b0, dq_w[QUO_BITS]};
        sum        = {{(SUM_BITS-WORD_BITS){out_lo[WORD_BITS-1]}}, out_lo}
                   + {q_signed[QUO_BITS], q_signed};
        upper_bits = sum[SUM_BITS-1:WORD_BITS-1];
        if (divisor_w[QUO_BITS] == '0)
        begin
            c_next = out_lo;
        end
        else if ((&upper_bits) || !(|upper_bits))
        begin
            c_next = sum[WORD_BITS-1:0];
        end
        else if (sum[SUM_BITS-1])
        begin
            c_next = {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else
        begin
            c_next = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (last.valid && !last.tag)
        begin
            c_re_reg <= c_next;
        end
        if (last.valid && last.tag)
        begin
            c_im_reg <= c_next;
        end
    end

    assign done = done_reg;
    assign c_re = c_re_reg;
    assign c_im = c_im_reg;

endmodule

/* src/mbm_iter_core.sv */
`timescale 1ns / 1ps
module mbm_iter_core #(
    parameter int WORD_BITS = mbm_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mbm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [WORD_BITS-1:0]   c_re,
    input  logic signed [WORD_BITS-1:0]   c_im,
    input  logic [mbm_pkg::LIMIT_BITS-1:0] limit,
    output logic                          done,
    output logic                          in_set
);
    import mbm_pkg::*;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam logic [PROD_BITS:0] ESCAPE_BOUND = (PROD_BITS+1)'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [2:0] {
        IT_IDLE = 3'b001,
        IT_MUL  = 3'b010,
        IT_STEP = 3'b100
    } iter_state_t;

    iter_state_t state_reg;
    logic [LIMIT_BITS-1:0]       count_reg;
    logic signed [WORD_BITS-1:0] zr_reg;
    logic signed [WORD_BITS-1:0] zi_reg;
    logic signed [PROD_BITS-1:0] sq_re_reg;
    logic signed [PROD_BITS-1:0] sq_im_reg;
    logic signed [PROD_BITS-1:0] cross_reg;
    logic signed [PROD_BITS-1:0] sq_re_next;
    logic signed [PROD_BITS-1:0] sq_im_next;
    logic signed [PROD_BITS-1:0] cross_next;
    logic                        done_reg;
    logic                        inside_reg;

    logic [PROD_BITS:0]          mag;
    logic                        escape;
    logic signed [PROD_BITS:0]   re_full;
    logic signed [PROD_BITS:0]   re_shift;
    logic signed [PROD_BITS-1:0] im_shift;
    logic signed [SUM_BITS-1:0]  re_sum;
    logic signed [SUM_BITS-1:0]  im_sum;
    logic signed [WORD_BITS-1:0] zr_next;
    logic signed [WORD_BITS-1:0] zi_next;

    function automatic logic signed [WORD_BITS-1:0] clamp(input logic signed [SUM_BITS-1:0] v);
        logic [SUM_BITS-WORD_BITS:0] upper_bits;
        begin
            upper_bits = v[SUM_BITS-1:WORD_BITS-1];
            if ((&upper_bits) || !(|upper_bits))
            begin
                clamp = v[WORD_BITS-1:0];
            end
            else if (v[SUM_BITS-1])
            begin
                clamp = {1'b1, {(WORD_BITS-1){1'b0}}};
            end
            else
            begin
                clamp = {1'b0, {(WORD_BITS-1){1'b1}}};
            end
        end
    endfunction

    always_comb
    begin
        sq_re_next = zr_reg * zr_reg;
        sq_im_next = zi_reg * zi_reg;
        cross_next = zr_reg * zi_reg;
        mag        = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
        escape     = (mag > ESCAPE_BOUND);
        re_full    = {sq_re_reg[PROD_BITS-1], sq_re_reg} - {sq_im_reg[PROD_BITS-1], sq_im_reg};
        re_shift   = re_full >>> FRAC_BITS;
        im_shift   = cross_reg >>> (FRAC_BITS - 1);
        re_sum     = {re_shift[PROD_BITS], re_shift}
                   + {{(WORD_BITS+2){c_re[WORD_BITS-1]}}, c_re};
        im_sum     = {{2{im_shift[PROD_BITS-1]}}, im_shift}
                   + {{(WORD_BITS+2){c_im[WORD_BITS-1]}}, c_im};
        zr_next    = clamp(re_sum);
        zi_next    = clamp(im_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IT_IDLE;
            count_reg <= '0;
            zr_reg    <= '0;
            zi_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                IT_IDLE:
                begin
                    if (start)
                    begin
                        zr_reg    <= '0;
                        zi_reg    <= '0;
                        count_reg <= '0;
                        state_reg <= IT_MUL;
                    end
                end
                IT_MUL:
                begin
                    state_reg <= IT_STEP;
                end
                IT_STEP:
                begin
                    if ((count_reg != '0) && escape)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= IT_IDLE;
                    end
                    else if (count_reg == limit)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= IT_IDLE;
                    end
                    else
                    begin
                        zr_reg    <= zr_next;
                        zi_reg    <= zi_next;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= IT_MUL;
                    end
                end
                default:
                begin
                    state_reg <= IT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == IT_MUL)
        begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
            cross_reg <= cross_next;
        end
        if (state_reg == IT_STEP)
        begin
            inside_reg <= !((count_reg != '0) && escape);
        end
    end

    assign done   = done_reg;
    assign in_set = inside_reg;

endmodule

/* src/mandelbrot_membership_unit.sv */
// Each pixel word passes the mapping divider chain (x, then y) and then the iteration
// loop, which runs n iterations, each an IT_MUL state followed by an IT_STEP state.
// One pixel at a time: the next input word is taken no earlier than the cycle after
// the result enters the output register.
// Reset (rst_n low, asynchronous) clears control and loads default registers.
`timescale 1ns / 1ps
module mandelbrot_membership_unit #(
    parameter int WORD_BITS  = mbm_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS  = mbm_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbm_pkg::COORD_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // column, row
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // inside_res, column_out, row_out
    output logic [((2*COORD_BITS+1+7)/8)*8-1:0]     m_axis_tdata,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mbm_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [WORD_BITS-1:0]                    cfg_data
);
    import mbm_pkg::*;

    localparam int OUT_DATA_BITS = ((2*COORD_BITS+1+7)/8)*8;
    localparam logic [WORD_BITS-1:0] ONE_FX      = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [WORD_BITS-1:0] MIN_X_RESET = WORD_BITS'(0) - (ONE_FX << 1);
    localparam logic [WORD_BITS-1:0] MIN_Y_RESET = WORD_BITS'(0) - ONE_FX;

    typedef enum logic [3:0] {
        TOP_IDLE = 4'b0001,
        TOP_MAP  = 4'b0010,
        TOP_ITER = 4'b0100,
        TOP_OUT  = 4'b1000
    } top_state_t;

    top_state_t state_reg;

    logic [LIMIT_BITS-1:0]       limit_reg;
    logic signed [WORD_BITS-1:0] min_x_reg;
    logic signed [WORD_BITS-1:0] max_x_reg;
    logic signed [WORD_BITS-1:0] min_y_reg;
    logic signed [WORD_BITS-1:0] max_y_reg;
    logic [COORD_BITS-1:0]       grid_w_reg;
    logic [COORD_BITS-1:0]       grid_h_reg;

    logic [COORD_BITS-1:0]       col_reg;
    logic [COORD_BITS-1:0]       row_reg;
    logic                        map_start_reg;
    logic                        m_valid_reg;
    logic [OUT_DATA_BITS-1:0]    m_data_reg;

    logic                        in_accept;
    logic                        map_done;
    logic signed [WORD_BITS-1:0] c_re;
    logic signed [WORD_BITS-1:0] c_im;
    logic                        iter_start;
    logic                        iter_done;
    logic                        iter_inside;
    logic                        out_free;

    assign s_axis_tready = (state_reg == TOP_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign iter_start    = (state_reg == TOP_MAP) && map_done;
    assign out_free      = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            min_x_reg  <= MIN_X_RESET;
            max_x_reg  <= ONE_FX;
            min_y_reg  <= MIN_Y_RESET;
            max_y_reg  <= ONE_FX;
            grid_w_reg <= COORD_BITS'(GRID_W_RESET);
            grid_h_reg <= COORD_BITS'(GRID_H_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ITER_LIMIT: limit_reg  <= cfg_data[LIMIT_BITS-1:0];
                REG_MIN_X:      min_x_reg  <= cfg_data;
                REG_MAX_X:      max_x_reg  <= cfg_data;
                REG_MIN_Y:      min_y_reg  <= cfg_data;
                REG_MAX_Y:      max_y_reg  <= cfg_data;
                REG_GRID_W:     grid_w_reg <= cfg_data[COORD_BITS-1:0];
                REG_GRID_H:     grid_h_reg <= cfg_data[COORD_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            map_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            map_start_reg <= in_accept;
            if ((state_reg == TOP_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                TOP_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= TOP_MAP;
                    end
                end
                TOP_MAP:
                begin
                    if (map_done)
                    begin
                        state_reg <= TOP_ITER;
                    end
                end
                TOP_ITER:
                begin
                    if (iter_done)
                    begin
                        state_reg <= TOP_OUT;
                    end
                end
                TOP_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= TOP_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= TOP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            col_reg <= s_axis_tdata[COORD_BITS-1:0];
            row_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
        if ((state_reg == TOP_OUT) && out_free)
        begin
            m_data_reg <= OUT_DATA_BITS'({row_reg, col_reg, iter_inside});
        end
    end

    mbm_map_chain #(
        .WORD_BITS  (WORD_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (map_start_reg),
        .pos_x  (col_reg),
        .pos_y  (row_reg),
        .min_x  (min_x_reg),
        .max_x  (max_x_reg),
        .min_y  (min_y_reg),
        .max_y  (max_y_reg),
        .grid_w (grid_w_reg),
        .grid_h (grid_h_reg),
        .done   (map_done),
        .c_re   (c_re),
        .c_im   (c_im)
    );

    mbm_iter_core #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (iter_start),
        .c_re   (c_re),
        .c_im   (c_im),
        .limit  (limit_reg),
        .done   (iter_done),
        .in_set (iter_inside)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* test/mbm_checker.sv */
`timescale 1ns / 1ps
module mbm_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    // column, row
    input  logic [((2*mbm_pkg::COORD_BITS_DEF+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // inside_res, column_out, row_out
    input  logic [((2*mbm_pkg::COORD_BITS_DEF+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [mbm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mbm_pkg::WORD_BITS_DEF-1:0]      cfg_data,
    output int                                     pending,
    output int                                     mismatches
);

    localparam int WB = mbm_pkg::WORD_BITS_DEF;
    localparam int FB = mbm_pkg::FRAC_BITS_DEF;
    localparam int CB = mbm_pkg::COORD_BITS_DEF;
    localparam int LB = mbm_pkg::LIMIT_BITS;
    localparam logic signed [WB-1:0] UNIT = 1 <<< FB;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [WB-1:0] fixed_t;

    typedef struct packed {
        logic          bounded;
        logic [CB-1:0] col;
        logic [CB-1:0] row;
    } pixel_verdict_t;

    pixel_verdict_t expected_verdicts[$];

    logic [LB-1:0] limit_reg;
    fixed_t        lo_re;
    fixed_t        hi_re;
    fixed_t        lo_im;
    fixed_t        hi_im;
    logic [CB-1:0] cols_reg;
    logic [CB-1:0] rows_reg;

    function automatic fixed_t clamp_word(input wide_t v);
        wide_t top_v;
        wide_t bot_v;
        top_v = (wide_t'(1) <<< (WB-1)) - wide_t'(1);
        bot_v = -top_v - wide_t'(1);
        if (v > top_v)
            return top_v[WB-1:0];
        if (v < bot_v)
            return bot_v[WB-1:0];
        return v[WB-1:0];
    endfunction

    function automatic fixed_t map_to_plane(input fixed_t lo, input fixed_t hi,
                                            input logic [CB-1:0] pos,
                                            input logic [CB-1:0] grid);
        wide_t span;
        wide_t pos_w;
        wide_t grid_w;
        wide_t quot;
        if (grid == '0)
            return lo;
        span   = wide_t'(hi) - wide_t'(lo);
        pos_w  = wide_t'(pos);
        grid_w = wide_t'(grid);
        quot   = (span * pos_w) / grid_w;
        return clamp_word(quot + wide_t'(lo));
    endfunction

    function automatic logic pixel_stays_bounded(input fixed_t cr, input fixed_t ci,
                                                 input logic [LB-1:0] limit);
        fixed_t zr;
        fixed_t zi;
        wide_t  re;
        wide_t  im;
        wide_t  mag;
        wide_t  disc_bound;
        logic   escaped;
        int     step;
        zr         = '0;
        zi         = '0;
        escaped    = 1'b0;
        disc_bound = wide_t'(1) <<< (2*FB + 2);
        for (step = 0; step < limit && !escaped; step++)
        begin
            re      = wide_t'(zr) * wide_t'(zr) - wide_t'(zi) * wide_t'(zi);
            im      = wide_t'(zr) * wide_t'(zi);
            zr      = clamp_word((re >>> FB) + wide_t'(cr));
            zi      = clamp_word((im >>> (FB-1)) + wide_t'(ci));
            mag     = wide_t'(zr) * wide_t'(zr) + wide_t'(zi) * wide_t'(zi);
            escaped = (mag > disc_bound);
        end
        return !escaped;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_verdict_t want;
        logic           got_inside;
        logic [CB-1:0]  got_col;
        logic [CB-1:0]  got_row;
        fixed_t         cr;
        fixed_t         ci;
        if (!rst_n)
        begin
            limit_reg  = mbm_pkg::LIMIT_RESET;
            lo_re      = -2*UNIT;
            hi_re      = UNIT;
            lo_im      = -UNIT;
            hi_im      = UNIT;
            cols_reg   = CB'(mbm_pkg::GRID_W_RESET);
            rows_reg   = CB'(mbm_pkg::GRID_H_RESET);
            mismatches = 0;
            expected_verdicts.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_inside = m_axis_tdata[0];
                got_col    = m_axis_tdata[CB:1];
                got_row    = m_axis_tdata[2*CB:CB+1];
                if (expected_verdicts.size() == 0)
                    flag_mismatch($sformatf("unexpected result word (%0d,%0d) inside=%0b",
                                            got_col, got_row, got_inside));
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got_inside !== want.bounded)
                        flag_mismatch($sformatf("inside_res for (%0d,%0d): got %0b, want %0b",
                                                want.col, want.row, got_inside,
                                                want.bounded));
                    if (got_col !== want.col)
                        flag_mismatch($sformatf("column_out: got %0d, want %0d",
                                                got_col, want.col));
                    if (got_row !== want.row)
                        flag_mismatch($sformatf("row_out: got %0d, want %0d",
                                                got_row, want.row));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want.col     = s_axis_tdata[CB-1:0];
                want.row     = s_axis_tdata[2*CB-1:CB];
                cr           = map_to_plane(lo_re, hi_re, want.col, cols_reg);
                ci           = map_to_plane(lo_im, hi_im, want.row, rows_reg);
                want.bounded = pixel_stays_bounded(cr, ci, limit_reg);
                expected_verdicts.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mbm_pkg::REG_ITER_LIMIT: limit_reg = cfg_data[LB-1:0];
                    mbm_pkg::REG_MIN_X:      lo_re     = cfg_data;
                    mbm_pkg::REG_MAX_X:      hi_re     = cfg_data;
                    mbm_pkg::REG_MIN_Y:      lo_im     = cfg_data;
                    mbm_pkg::REG_MAX_Y:      hi_im     = cfg_data;
                    mbm_pkg::REG_GRID_W:     cols_reg  = cfg_data[CB-1:0];
                    mbm_pkg::REG_GRID_H:     rows_reg  = cfg_data[CB-1:0];
                    default: ;
                endcase
            end
            pending <= expected_verdicts.size();
        end
    end

endmodule

/* test/tb_mandelbrot_membership_unit.sv */
`timescale 1ns / 1ps
module tb_mandelbrot_membership_unit;

    localparam int CB            = mbm_pkg::COORD_BITS_DEF;
    localparam int WB            = mbm_pkg::WORD_BITS_DEF;
    localparam int IB            = mbm_pkg::CFG_INDEX_BITS;
    localparam int IN_W          = ((2*CB+7)/8)*8;
    localparam int OUT_W         = ((2*CB+1+7)/8)*8;
    localparam int UNIT          = 1 << mbm_pkg::FRAC_BITS_DEF;
    localparam int HALF_PERIOD   = 2;
    localparam int HOLD_CYCLES   = 6000;
    localparam int SETTLE_CYCLES = 2200;
    localparam int ITEM_TARGET   = 1450;
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam logic [IB-1:0] REG_SPARE = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IB-1:0]    cfg_index;
    logic [WB-1:0]    cfg_data;

    int pending;
    int mismatches;
    int pixels_sent;
    int burst_left;
    int hold_requests;

    logic [IB-1:0] reg_index_q[$];
    logic [WB-1:0] reg_value_q[$];

    always #(HALF_PERIOD) clk = ~clk;

    mandelbrot_membership_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mbm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    task automatic queue_reg(input logic [IB-1:0] idx, input logic [WB-1:0] value);
        reg_index_q.push_back(idx);
        reg_value_q.push_back(value);
    endtask

    task automatic commit_registers();
        while (reg_index_q.size() > 0)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index_q.pop_front();
            cfg_data  <= reg_value_q.pop_front();
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_pixel(input logic [CB-1:0] col, input logic [CB-1:0] row);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-2*CB){1'b0}}, row, col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        pixels_sent++;
    endtask

    // drop valid and hold until every result word is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [WB-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WB-1:0] pick_grid();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(64, 1023);
            1:       return $urandom;
            2:       return '0;
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_position(input logic [CB-1:0] grid);
        if ($urandom_range(0, 4) == 0)
            return CB'($urandom_range(0, 1023));
        if (grid == '0)
            return CB'($urandom_range(0, 3));
        return CB'($urandom_range(0, grid));
    endfunction

    initial
    begin : receiver
        int rx_cycle;
        int rx_mode;
        int hold_left;
        int holds_served;
        rx_cycle      = 0;
        rx_mode       = 0;
        hold_left     = 0;
        holds_served  = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle % 256 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int lim_val;
        int gw_val;
        int gh_val;
        int x0;
        int x1;
        int y0;
        int y1;
        int swap_tmp;
        int wmode;
        int pick;
        int big_phases;
        int phase;
        int n;
        int k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pixels_sent   = 0;
        burst_left    = 0;
        hold_requests = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, beyond the grid, alternating bits
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd37, 10'd24);
        offer_pixel(10'd38, 10'd25);
        offer_pixel(10'd19, 10'd12);
        offer_pixel(10'h2AA, 10'h155);
        offer_pixel(10'h155, 10'h2AA);
        wait_idle();

        // zero limit and zero grid, via bits above the register width
        queue_reg(mbm_pkg::REG_ITER_LIMIT, 32'h0000_0400);
        queue_reg(mbm_pkg::REG_GRID_W, 32'h0000_0000);
        queue_reg(mbm_pkg::REG_GRID_H, 32'hFFFF_FC00);
        commit_registers();
        offer_pixel(10'd5, 10'd7);
        offer_pixel(10'd1023, 10'd0);
        wait_idle();

        // full number range, imaginary axis inverted, largest limit and grid
        queue_reg(mbm_pkg::REG_ITER_LIMIT, 32'd1023);
        queue_reg(mbm_pkg::REG_MIN_X, 32'h8000_0000);
        queue_reg(mbm_pkg::REG_MAX_X, 32'h7fff_ffff);
        queue_reg(mbm_pkg::REG_MIN_Y, 32'h7fff_ffff);
        queue_reg(mbm_pkg::REG_MAX_Y, 32'h8000_0000);
        queue_reg(mbm_pkg::REG_GRID_W, 32'd1023);
        queue_reg(mbm_pkg::REG_GRID_H, 32'd1023);
        queue_reg(REG_SPARE, 32'hFFFF_FFFF);
        commit_registers();
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd511, 10'd512);
        wait_idle();

        // one iteration, real axis inverted, one-cell grid, positions past it
        queue_reg(mbm_pkg::REG_ITER_LIMIT, 32'd1);
        queue_reg(mbm_pkg::REG_MIN_X, UNIT);
        queue_reg(mbm_pkg::REG_MAX_X, -2*UNIT);
        queue_reg(mbm_pkg::REG_MIN_Y, -UNIT);
        queue_reg(mbm_pkg::REG_MAX_Y, UNIT);
        queue_reg(mbm_pkg::REG_GRID_W, 32'd1);
        queue_reg(mbm_pkg::REG_GRID_H, 32'd1);
        commit_registers();
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1, 10'd1);
        offer_pixel(10'd2, 10'd3);
        wait_idle();

        // cardioid cusp, centre, and period-two bulb
        queue_reg(mbm_pkg::REG_ITER_LIMIT, 32'd200);
        queue_reg(mbm_pkg::REG_MIN_X, -2*UNIT);
        queue_reg(mbm_pkg::REG_MAX_X, UNIT);
        queue_reg(mbm_pkg::REG_GRID_W, 32'd64);
        queue_reg(mbm_pkg::REG_GRID_H, 32'd64);
        commit_registers();
        offer_pixel(10'd48, 10'd32);
        offer_pixel(10'd32, 10'd32);
        offer_pixel(10'd21, 10'd32);
        wait_idle();

        big_phases = 0;
        phase      = 0;
        while (pixels_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0 && big_phases < 3)
            begin
                lim_val = 1023;
                big_phases++;
            end
            else if (pick == 1)
                lim_val = 1;
            else if (pick == 2)
                lim_val = $urandom << 10;
            else
                lim_val = $urandom_range(2, 80)
                        | (($urandom_range(0, 3) == 0) ? ($urandom << 10) : 0);

            wmode = $urandom_range(0, 5);
            if (wmode == 0)
            begin
                x0 = $urandom;
                x1 = $urandom;
                y0 = $urandom;
                y1 = $urandom;
            end
            else if (wmode == 1)
            begin
                x0 = pick_extreme();
                x1 = pick_extreme();
                y0 = pick_extreme();
                y1 = pick_extreme();
            end
            else
            begin
                x0 = -671088640 + $urandom_range(0, 536870912);
                x1 = x0 + $urandom_range(65536, 805306368);
                y0 = -402653184 + $urandom_range(0, 402653184);
                y1 = y0 + $urandom_range(65536, 805306368);
                if ($urandom_range(0, 7) == 0)
                begin
                    swap_tmp = x0;
                    x0       = x1;
                    x1       = swap_tmp;
                end
            end
            gw_val = pick_grid();
            gh_val = pick_grid();

            queue_reg(mbm_pkg::REG_ITER_LIMIT, lim_val);
            queue_reg(mbm_pkg::REG_MIN_X, x0);
            queue_reg(mbm_pkg::REG_MAX_X, x1);
            queue_reg(mbm_pkg::REG_MIN_Y, y0);
            queue_reg(mbm_pkg::REG_MAX_Y, y1);
            queue_reg(mbm_pkg::REG_GRID_W, gw_val);
            queue_reg(mbm_pkg::REG_GRID_H, gh_val);
            if ($urandom_range(0, 3) == 0)
                queue_reg(REG_SPARE, $urandom);
            commit_registers();

            n = (lim_val[9:0] > 200) ? 10 : $urandom_range(40, 110);
            for (k = 0; k < n; k++)
            begin
                if (phase == 2 && k == 5)
                    hold_requests <= hold_requests + 1;
                offer_pixel(pick_position(gw_val[CB-1:0]), pick_position(gh_val[CB-1:0]));
            end
            wait_idle();
            phase++;
        end

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS mandelbrot_membership_unit");
        else
            $display("FAIL mandelbrot_membership_unit");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL mandelbrot_membership_unit");
        $finish;
    end

endmodule
